// ----- hw/rtl/owvm_pkg.sv -----
`default_nettype none
package owvm_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CFG_IDX_W     = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_DIST = 2'd1;

    localparam logic [15:0] INV_RADIUS_RST  = 16'd5120;
    localparam logic [15:0] CENTER_DIST_RST = 16'd23170;

    // cordic gain in Q1.30 and 1/sqrt(2) in Q0.16
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [16:0] INV_SQRT2   = 17'sd46341;

    localparam logic signed [18:0] WHEEL_MAX = 19'sh3FFFF;
    localparam logic signed [18:0] WHEEL_MIN = 19'sh40000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [16:0] vx;
        logic signed [16:0] vy;
        logic signed [15:0] om;
    } t_cell;

    // arctangent of 2^-i, 2^32 counts per turn
    function automatic logic signed [31:0] atan_q32(input logic [3:0] idx);
        logic signed [31:0] v;
        case (idx)
            4'd0:    v = 32'sd536870912;
            4'd1:    v = 32'sd316933406;
            4'd2:    v = 32'sd167458907;
            4'd3:    v = 32'sd85004756;
            4'd4:    v = 32'sd42667331;
            4'd5:    v = 32'sd21354465;
            4'd6:    v = 32'sd10679838;
            4'd7:    v = 32'sd5340245;
            4'd8:    v = 32'sd2670163;
            4'd9:    v = 32'sd1335087;
            4'd10:   v = 32'sd667544;
            4'd11:   v = 32'sd333772;
            4'd12:   v = 32'sd166886;
            4'd13:   v = 32'sd83443;
            4'd14:   v = 32'sd41722;
            default: v = 32'sd20861;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/owvm_if.sv -----
`default_nettype none
interface owvm_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] world_vel_x;
    logic signed [15:0] world_vel_y;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] heading;

    modport source (output valid, world_vel_x, world_vel_y, yaw_rate, heading,
                    input ready);
    modport sink   (input valid, world_vel_x, world_vel_y, yaw_rate, heading,
                    output ready);
endinterface

interface owvm_wheel_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] wheel_one_speed;
    logic signed [18:0] wheel_two_speed;
    logic signed [18:0] wheel_three_speed;
    logic signed [18:0] wheel_four_speed;

    modport source (output valid, wheel_one_speed, wheel_two_speed, wheel_three_speed,
                    wheel_four_speed, input ready);
    modport sink   (input valid, wheel_one_speed, wheel_two_speed, wheel_three_speed,
                    wheel_four_speed, output ready);
endinterface

interface owvm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/owvm_cordic_cell.sv -----
`default_nettype none
module owvm_cordic_cell
    import owvm_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_cell i_data,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_cell      o_data
);

    localparam logic [3:0] IDX = 4'(STAGE);

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;
    logic  load;

    // a cell takes a new word when empty or when its word moves on
    assign load    = !r_valid || i_ready;
    assign o_ready = load;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        if (!i_data.z[31]) begin
            n_data.x = i_data.x - ($signed(i_data.y) >>> STAGE);
            n_data.y = i_data.y + ($signed(i_data.x) >>> STAGE);
            n_data.z = i_data.z - atan_q32(IDX);
        end else begin
            n_data.x = i_data.x + ($signed(i_data.y) >>> STAGE);
            n_data.y = i_data.y - ($signed(i_data.x) >>> STAGE);
            n_data.z = i_data.z + atan_q32(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/owvm_wheel_lane.sv -----
`default_nettype none
module owvm_wheel_lane
    import owvm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [3:0]         i_en,
    input  wire logic signed [35:0] i_diag,
    input  wire logic signed [32:0] i_spin,
    input  wire logic [15:0]        i_inv_radius,
    output logic signed [18:0]      o_speed
);

    logic signed [52:0] r_prod;
    logic signed [33:0] r_sum24;
    logic signed [50:0] r_wide;
    logic signed [18:0] r_speed;

    logic signed [53:0] sum44;
    logic signed [50:0] wide_rnd;
    logic signed [26:0] w_rnd;
    logic signed [18:0] n_speed;

    // diag/sqrt(2) plus spin term, both Q.44, rounded to Q.24
    assign sum44 = 54'(r_prod) + 54'($signed({i_spin, 16'b0})) + 54'sd524288;

    assign wide_rnd = r_wide + 51'sd8388608;
    assign w_rnd    = wide_rnd[50:24];

    always_comb begin
        if (w_rnd > 27'(WHEEL_MAX)) begin
            n_speed = WHEEL_MAX;
        end else if (w_rnd < 27'(WHEEL_MIN)) begin
            n_speed = WHEEL_MIN;
        end else begin
            n_speed = w_rnd[18:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= 53'(i_diag) * 53'(INV_SQRT2);
        end
        if (i_en[1]) begin
            r_sum24 <= sum44[53:20];
        end
        if (i_en[2]) begin
            r_wide <= 51'(r_sum24) * 51'($signed({1'b0, i_inv_radius}));
        end
        if (i_en[3]) begin
            r_speed <= n_speed;
        end
    end

    assign o_speed = r_speed;

endmodule
`default_nettype wire

// ----- hw/rtl/omni_wheel_velocity_mixer.sv -----
// path: an accepted command word enters the first of 16 cordic cells, then
//   passes 7 mixing stages ending in the output register
// throughput: one command word per cycle; each cell and stage forwards or
//   fills a bubble on its own, so input stalls only when every stage is full
//   and the output is held
// reset: clears all valid bits and loads the register defaults (5120, 23170)
`default_nettype none
module omni_wheel_velocity_mixer
    import owvm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    owvm_cmd_if.sink     i_cmd,
    owvm_wheel_if.source o_wheel,
    owvm_cfg_if.sink     i_cfg
);

    localparam int POST = 7;

    // configuration
    logic [15:0] r_inv_radius;
    logic [15:0] r_center_dist;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_radius  <= INV_RADIUS_RST;
            r_center_dist <= CENTER_DIST_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_INV_RADIUS:  r_inv_radius  <= i_cfg.data;
                REG_CENTER_DIST: r_center_dist <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // entry: heading folded into +-90 degrees, command negated when folded
    logic signed [32:0] z_full;
    logic signed [32:0] z_fold;
    logic               flip;
    t_cell              entry;

    always_comb begin
        z_full = $signed({i_cmd.heading[15], i_cmd.heading, 16'b0});
        z_fold = z_full;
        flip   = 1'b0;
        if (z_full > 33'sd1073741824) begin
            z_fold = z_full - 33'sd2147483648;
            flip   = 1'b1;
        end else if (z_full < -33'sd1073741824) begin
            z_fold = z_full + 33'sd2147483648;
            flip   = 1'b1;
        end
        entry.x  = CORDIC_GAIN;
        entry.y  = 32'sd0;
        entry.z  = z_fold[31:0];
        entry.vx = flip ? -17'(i_cmd.world_vel_x) : 17'(i_cmd.world_vel_x);
        entry.vy = flip ? -17'(i_cmd.world_vel_y) : 17'(i_cmd.world_vel_y);
        entry.om = i_cmd.yaw_rate;
    end

    // cordic chain
    logic  cv [0:CORDIC_STAGES];
    logic  cr [0:CORDIC_STAGES];
    t_cell cd [0:CORDIC_STAGES];
    logic  adv [0:POST];

    assign cv[0]         = i_cmd.valid;
    assign cd[0]         = entry;
    assign i_cmd.ready   = cr[0];
    assign cr[CORDIC_STAGES] = adv[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        owvm_cordic_cell #(.STAGE(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[k]),
            .o_ready (cr[k]),
            .i_data  (cd[k]),
            .o_valid (cv[k+1]),
            .i_ready (cr[k+1]),
            .o_data  (cd[k+1])
        );
    end

    // mixing stages: valid bits and per-stage advance
    logic r_pv [0:POST-1];

    assign adv[POST] = o_wheel.ready;
    for (genvar k = 0; k < POST; k++) begin : g_adv
        assign adv[k] = !r_pv[k] || adv[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POST; k++) begin
                r_pv[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                r_pv[0] <= cv[CORDIC_STAGES];
            end
            for (int k = 1; k < POST; k++) begin
                if (adv[k]) begin
                    r_pv[k] <= r_pv[k-1];
                end
            end
        end
    end

    // body frame rotation: products, then rounded sums to Q.28
    t_cell              last;
    logic signed [48:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [32:0] r_spin [0:3];
    logic signed [34:0] r_vs, r_vp;
    logic signed [35:0] r_diag [0:3];
    logic signed [49:0] sum_s, sum_p;

    assign last  = cd[CORDIC_STAGES];
    assign sum_s = 50'(r_pa) + 50'(r_pb) + 50'sd8192;
    assign sum_p = 50'(r_pc) - 50'(r_pd) + 50'sd8192;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_pa      <= 49'(last.vx) * 49'(last.x);
            r_pb      <= 49'(last.vy) * 49'(last.y);
            r_pc      <= 49'(last.vy) * 49'(last.x);
            r_pd      <= 49'(last.vx) * 49'(last.y);
            r_spin[0] <= 33'($signed({1'b0, r_center_dist})) * 33'(last.om);
        end
        if (adv[1]) begin
            r_vs      <= sum_s[48:14];
            r_vp      <= sum_p[48:14];
            r_spin[1] <= r_spin[0];
        end
        if (adv[2]) begin
            r_diag[0] <= 36'(r_vp) - 36'(r_vs);
            r_diag[1] <= -36'(r_vs) - 36'(r_vp);
            r_diag[2] <= 36'(r_vs) - 36'(r_vp);
            r_diag[3] <= 36'(r_vs) + 36'(r_vp);
            r_spin[2] <= r_spin[1];
        end
        if (adv[3]) begin
            r_spin[3] <= r_spin[2];
        end
    end

    // per wheel lanes
    logic [3:0]         lane_en;
    logic signed [18:0] speed [0:3];

    assign lane_en = {adv[6], adv[5], adv[4], adv[3]};

    for (genvar w = 0; w < 4; w++) begin : g_lane
        owvm_wheel_lane u_lane (
            .i_clk        (i_clk),
            .i_en         (lane_en),
            .i_diag       (r_diag[w]),
            .i_spin       (r_spin[3]),
            .i_inv_radius (r_inv_radius),
            .o_speed      (speed[w])
        );
    end

    assign o_wheel.valid             = r_pv[POST-1];
    assign o_wheel.wheel_one_speed   = speed[0];
    assign o_wheel.wheel_two_speed   = speed[1];
    assign o_wheel.wheel_three_speed = speed[2];
    assign o_wheel.wheel_four_speed  = speed[3];

    // input stalls only when the whole chain is full and the output is held
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> (o_wheel.valid && !o_wheel.ready))
        else $error("input stalled with room in the pipeline");

    a_bubble_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv[0] && !r_pv[1]) |=> r_pv[1])
        else $error("word did not move into an empty stage");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wheel.valid && o_wheel.ready && !r_pv[POST-2]) |=> !o_wheel.valid)
        else $error("output word repeated after being taken");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.index == REG_INV_RADIUS) |=>
            (r_inv_radius == $past(i_cfg.data)))
        else $error("wheel radius register not written");

endmodule
`default_nettype wire
